### design/kmm_pkg.sv
// Package for the keyed message mailbox: default sizes, command and status codes, states.
`default_nettype none
package kmm_pkg;

    localparam int unsigned KMM_CAPACITY     = 16;
    localparam int unsigned KMM_ID_BITS      = 16;
    localparam int unsigned KMM_PAYLOAD_BITS = 32;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_PEEK  = 2'd1,
        CMD_POP   = 2'd2,
        CMD_COUNT = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### design/kmm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module kmm_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule
`default_nettype wire

### design/keyed_message_mailbox_core.sv
// Keyed message mailbox: ordered message store with per-target peek, pop and count.
// One item at a time: the input stalls from accept until the result is registered.
// Add: from accept straight to the done state; the result is registered there once the output is free.
// Peek and count read one entry per cycle until a hit ends a peek or the last entry is read.
// Pop adds a read restart just past the hit and a compaction pass over the later entries.
// Synchronous active-low reset empties the store (fill level 0); RAM contents persist.
`default_nettype none
module keyed_message_mailbox_core
    import kmm_pkg::*;
#(
    parameter int unsigned CAPACITY     = KMM_CAPACITY,
    parameter int unsigned ID_BITS      = KMM_ID_BITS,
    parameter int unsigned PAYLOAD_BITS = KMM_PAYLOAD_BITS,
    localparam int unsigned CW = $clog2(CAPACITY + 1),
    localparam int unsigned AW = $clog2(CAPACITY)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [1:0]              i_cmd,
    input  wire logic [ID_BITS-1:0]      i_target_id,
    input  wire logic [PAYLOAD_BITS-1:0] i_payload,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [1:0]                   o_status,
    output logic [ID_BITS-1:0]           o_msg_target,
    output logic [PAYLOAD_BITS-1:0]      o_msg_payload,
    output logic [CW-1:0]                o_match_count,
    output logic [CW-1:0]                o_total_count
);

    localparam int unsigned EW = ID_BITS + PAYLOAD_BITS;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    t_state r_state, n_state;

    t_cmd              r_cmd;
    logic [ID_BITS-1:0] r_id;
    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_chk_idx;
    logic              r_chk_valid;

    t_status               r_status;
    logic [ID_BITS-1:0]    r_mt;
    logic [PAYLOAD_BITS-1:0] r_mp;
    logic [CW-1:0]         r_mc;

    t_status                 r_out_status;
    logic [ID_BITS-1:0]      r_out_mt;
    logic [PAYLOAD_BITS-1:0] r_out_mp;
    logic [CW-1:0]           r_out_mc;
    logic [CW-1:0]           r_out_total;
    logic                    r_out_valid;

    logic          accept;
    t_cmd          in_cmd;
    logic          full;
    logic          issue;
    logic          hit;
    logic          last;
    logic          more_after;
    logic          shift_start;
    logic          out_free;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic [EW-1:0] rd_data;
    logic [ID_BITS-1:0] rd_target;
    logic [PAYLOAD_BITS-1:0] rd_payload;

    assign in_cmd      = t_cmd'(i_cmd);
    assign accept      = i_in_valid && !o_in_stall;
    assign full        = (r_fill >= CAP_C);
    assign rd_target   = rd_data[EW-1:PAYLOAD_BITS];
    assign rd_payload  = rd_data[PAYLOAD_BITS-1:0];
    assign hit         = (rd_target == r_id);
    assign last        = ((r_chk_idx + CW'(1)) == r_fill);
    assign more_after  = ((r_chk_idx + CW'(1)) < r_fill);
    assign shift_start = r_chk_valid && r_cmd == CMD_POP && hit && more_after;
    assign out_free    = !r_out_valid || !i_out_stall;

    kmm_ram #(
        .WIDTH(EW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(r_idx[AW-1:0]),
        .o_rd_data(rd_data)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (in_cmd == CMD_ADD || r_fill == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_chk_valid) begin
                    if (r_cmd != CMD_COUNT && hit) begin
                        if (r_cmd == CMD_POP && more_after) begin
                            n_state = S_SHIFT;
                        end else begin
                            n_state = S_DONE;
                        end
                    end else if (last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SHIFT: begin
                if (r_chk_valid && last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Outputs of the sequencer: input stall, RAM read issue and write port
    always_comb begin
        o_in_stall = 1'b1;
        issue      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_fill[AW-1:0];
        wr_data    = {i_target_id, i_payload};
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                wr_en      = accept && in_cmd == CMD_ADD && !full;
            end
            S_SCAN: begin
                issue = (r_idx < r_fill);
            end
            S_SHIFT: begin
                issue   = (r_idx < r_fill);
                // move the entry just read down one place
                wr_en   = r_chk_valid;
                wr_addr = AW'(r_chk_idx - CW'(1));
                wr_data = rd_data;
            end
            S_DONE: begin
                o_in_stall = 1'b1;
            end
            default: o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_fill      <= '0;
            r_chk_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_cmd       <= in_cmd;
                        r_id        <= i_target_id;
                        r_mt        <= '0;
                        r_mp        <= '0;
                        r_mc        <= '0;
                        r_idx       <= '0;
                        r_chk_valid <= 1'b0;
                        if (in_cmd == CMD_ADD && full) begin
                            r_status <= ST_FULL;
                        end else if (in_cmd != CMD_ADD && in_cmd != CMD_COUNT &&
                                     r_fill == '0) begin
                            r_status <= ST_NOT_FOUND;
                        end else begin
                            r_status <= ST_OK;
                        end
                        if (in_cmd == CMD_ADD && !full) begin
                            r_fill <= r_fill + CW'(1);
                        end
                    end
                end
                S_SCAN: begin
                    r_chk_valid <= issue && !shift_start;
                    r_chk_idx   <= r_idx;
                    if (shift_start) begin
                        // restart reads just past the hit for compaction
                        r_idx <= r_chk_idx + CW'(1);
                    end else if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_chk_valid) begin
                        if (r_cmd == CMD_COUNT) begin
                            if (hit) begin
                                r_mc <= r_mc + CW'(1);
                            end
                        end else if (hit) begin
                            r_mt <= rd_target;
                            r_mp <= rd_payload;
                            if (r_cmd == CMD_POP && !more_after) begin
                                r_fill <= r_fill - CW'(1);
                            end
                        end else if (last) begin
                            r_status <= ST_NOT_FOUND;
                        end
                    end
                end
                S_SHIFT: begin
                    r_chk_valid <= issue;
                    r_chk_idx   <= r_idx;
                    if (issue) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_chk_valid && last) begin
                        r_fill <= r_fill - CW'(1);
                    end
                end
                S_DONE: begin
                    r_chk_valid <= 1'b0;
                end
                default: r_chk_valid <= 1'b0;
            endcase

            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result register: loads only when the previous item has been taken
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_out_status <= r_status;
            r_out_mt     <= r_mt;
            r_out_mp     <= r_mp;
            r_out_mc     <= r_mc;
            r_out_total  <= r_fill;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_msg_target  = r_out_mt;
    assign o_msg_payload = r_out_mp;
    assign o_match_count = r_out_mc;
    assign o_total_count = r_out_total;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CAP_C)
        else $error("fill level above capacity");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(!i_rst_n) |-> (r_fill == $past(r_fill) ||
                              r_fill == $past(r_fill) + CW'(1) ||
                              r_fill == $past(r_fill) - CW'(1)))
        else $error("fill level moved by more than one");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_total_count == CAP_C))
        else $error("full status with store not at capacity");

    a_miss_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_NOT_FOUND) |->
            (o_msg_target == '0 && o_msg_payload == '0 && o_match_count == '0))
        else $error("not-found result carries message fields");

endmodule
`default_nettype wire

### sim/keyed_message_mailbox_core_tb.sv
// Self-checking testbench for the keyed message mailbox: directed and random add/peek/pop/count.
`default_nettype none
module keyed_message_mailbox_core_tb
    import kmm_pkg::*;
;

    localparam int CW          = $clog2(KMM_CAPACITY + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        t_status                     status;
        logic [KMM_ID_BITS-1:0]      target;
        logic [KMM_PAYLOAD_BITS-1:0] payload;
        logic [CW-1:0]               match;
        logic [CW-1:0]               total;
    } t_mbox_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic [1:0]                  i_cmd;
    logic [KMM_ID_BITS-1:0]      i_target_id;
    logic [KMM_PAYLOAD_BITS-1:0] i_payload;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic [1:0]                  o_status;
    logic [KMM_ID_BITS-1:0]      o_msg_target;
    logic [KMM_PAYLOAD_BITS-1:0] o_msg_payload;
    logic [CW-1:0]               o_match_count;
    logic [CW-1:0]               o_total_count;

    // mailbox contents as the block should hold them
    logic [KMM_ID_BITS-1:0]      mbox_target [KMM_CAPACITY];
    logic [KMM_PAYLOAD_BITS-1:0] mbox_payload [KMM_CAPACITY];
    int                          mbox_fill;
    logic [KMM_ID_BITS-1:0]      id_pool [4];

    t_mbox_result expected_results[$];
    t_mbox_result want;

    int errors;
    int results_checked;
    int full_seen;
    int miss_seen;
    int deep_counts;
    int cycle_count;
    int hold_request;
    int hold_left;
    bit quiet_mode;

    keyed_message_mailbox_core i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_cmd         (i_cmd),
        .i_target_id   (i_target_id),
        .i_payload     (i_payload),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_msg_target  (o_msg_target),
        .o_msg_payload (o_msg_payload),
        .o_match_count (o_match_count),
        .o_total_count (o_total_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("%0t: timeout with %0d results outstanding", $time,
                         expected_results.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Output side: random stalls, plus a counted hold-off on request.
    initial begin
        i_out_stall = 1'b0;
        hold_left   = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall = 1'b1;
            end else begin
                i_out_stall = !quiet_mode && ($urandom_range(0, 99) < 6);
            end
        end
    end

    // Apply one accepted item to the mailbox and queue the result it should give.
    task automatic predict_mailbox(input t_cmd cmd, input logic [KMM_ID_BITS-1:0] id,
                                   input logic [KMM_PAYLOAD_BITS-1:0] body);
        t_mbox_result r;
        int hit;
        r   = '0;
        hit = -1;
        case (cmd)
            CMD_ADD: begin
                if (mbox_fill >= KMM_CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    mbox_target[mbox_fill]  = id;
                    mbox_payload[mbox_fill] = body;
                    mbox_fill++;
                end
            end
            CMD_COUNT: begin
                for (int i = 0; i < mbox_fill; i++)
                    if (mbox_target[i] == id) r.match++;
            end
            default: begin
                for (int i = 0; i < mbox_fill; i++)
                    if (hit < 0 && mbox_target[i] == id) hit = i;
                if (hit < 0) begin
                    r.status = ST_NOT_FOUND;
                end else begin
                    r.target  = mbox_target[hit];
                    r.payload = mbox_payload[hit];
                    if (cmd == CMD_POP) begin
                        // close the gap, keep arrival order
                        for (int i = hit; i + 1 < mbox_fill; i++) begin
                            mbox_target[i]  = mbox_target[i + 1];
                            mbox_payload[i] = mbox_payload[i + 1];
                        end
                        mbox_fill--;
                    end
                end
            end
        endcase
        r.total = CW'(mbox_fill);
        expected_results.insert(expected_results.size(), r);
    endtask

    task automatic send_item(input t_cmd cmd, input logic [KMM_ID_BITS-1:0] id,
                             input logic [KMM_PAYLOAD_BITS-1:0] body);
        while (!quiet_mode && $urandom_range(0, 99) < 6) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_cmd       = cmd;
        i_target_id = id;
        i_payload   = body;
        do @(posedge i_clk); while (o_in_stall);
        predict_mailbox(cmd, id, body);
    endtask

    // Drop valid so a held item is not taken twice.
    task automatic input_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic logic [KMM_ID_BITS-1:0] pick_target();
        if ($urandom_range(0, 99) < 75) return id_pool[$urandom_range(0, 3)];
        return KMM_ID_BITS'($urandom_range(0, 65535));
    endfunction

    function automatic t_cmd pick_cmd();
        int roll;
        int add_pct;
        add_pct = (mbox_fill >= 14) ? 25 : ((mbox_fill <= 3) ? 60 : 40);
        roll    = $urandom_range(0, 99);
        if (roll < add_pct) return CMD_ADD;
        roll = $urandom_range(0, 99);
        if (roll < 35) return CMD_PEEK;
        if (roll < 75) return CMD_POP;
        return CMD_COUNT;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: status %0d target %h payload %h",
                         $time, o_status, o_msg_target, o_msg_payload);
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.status == ST_FULL) full_seen++;
                if (want.status == ST_NOT_FOUND) miss_seen++;
                if (want.match >= 8) deep_counts++;
                if (o_status !== want.status) begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, o_status);
                end
                if (o_msg_target !== want.target) begin
                    errors++;
                    $display("%0t: msg_target mismatch: expected %h actual %h",
                             $time, want.target, o_msg_target);
                end
                if (o_msg_payload !== want.payload) begin
                    errors++;
                    $display("%0t: msg_payload mismatch: expected %h actual %h",
                             $time, want.payload, o_msg_payload);
                end
                if (o_match_count !== want.match) begin
                    errors++;
                    $display("%0t: match_count mismatch: expected %0d actual %0d",
                             $time, want.match, o_match_count);
                end
                if (o_total_count !== want.total) begin
                    errors++;
                    $display("%0t: total_count mismatch: expected %0d actual %0d",
                             $time, want.total, o_total_count);
                end
            end
        end
    end

    task automatic test_empty_mailbox();
        send_item(CMD_PEEK, 16'h0000, $urandom);
        send_item(CMD_POP, 16'hFFFF, $urandom);
        send_item(CMD_COUNT, 16'h1234, $urandom);
        input_idle();
    endtask

    // Fill with one target so the count reaches capacity, then overflow.
    task automatic test_full_mailbox();
        for (int i = 0; i < KMM_CAPACITY; i++) begin
            if (i == 0)
                send_item(CMD_ADD, 16'hFFFF, 32'h0000_0000);
            else if (i == 1)
                send_item(CMD_ADD, 16'hFFFF, 32'hFFFF_FFFF);
            else
                send_item(CMD_ADD, 16'hFFFF, $urandom);
        end
        send_item(CMD_COUNT, 16'hFFFF, $urandom);
        send_item(CMD_ADD, 16'h0000, $urandom);
        send_item(CMD_PEEK, 16'hFFFF, $urandom);
        send_item(CMD_POP, 16'hFFFF, $urandom);
        input_idle();
    endtask

    task automatic test_random_traffic(input int n_items);
        int burst_left;
        t_cmd cmd;
        burst_left = 0;
        for (int n = 0; n < n_items; n++) begin
            // push toward full now and then
            if (n % 150 == 75) burst_left = 20;
            if (burst_left > 0) begin
                burst_left--;
                cmd = CMD_ADD;
            end else begin
                cmd = pick_cmd();
            end
            send_item(cmd, pick_target(), $urandom);
        end
        input_idle();
    endtask

    task automatic test_output_holdoff();
        hold_request = 300;
        for (int n = 0; n < 25; n++)
            send_item(pick_cmd(), pick_target(), $urandom);
        input_idle();
    endtask

    task automatic test_back_to_back();
        quiet_mode = 1'b1;
        test_random_traffic(200);
        quiet_mode = 1'b0;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_cmd           = CMD_ADD;
        i_target_id     = '0;
        i_payload       = '0;
        mbox_fill       = 0;
        errors          = 0;
        results_checked = 0;
        full_seen       = 0;
        miss_seen       = 0;
        deep_counts     = 0;
        hold_request    = 0;
        quiet_mode      = 1'b0;
        id_pool[0]      = 16'h0000;
        id_pool[1]      = 16'hFFFF;
        id_pool[2]      = KMM_ID_BITS'($urandom_range(0, 65535));
        id_pool[3]      = KMM_ID_BITS'($urandom_range(0, 65535));
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_mailbox();
        test_full_mailbox();
        test_random_traffic(600);
        test_output_holdoff();
        test_back_to_back();

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Checked %0d results: %0d full adds, %0d misses, %0d counts of 8 or more.",
                 results_checked, full_seen, miss_seen, deep_counts);
        $display("Covered empty and full mailbox, output hold-off and back-to-back traffic.");
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
`default_nettype wire

### filelist.f
design/kmm_pkg.sv
design/kmm_ram.sv
design/keyed_message_mailbox_core.sv
sim/keyed_message_mailbox_core_tb.sv
